/* hw/rtl/mabp_pkg.sv */
// Shared types and constants for the modulated alpha blend pixel pipeline.
// No dependencies; used by modulated_alpha_blend_pixel.
`default_nettype none

package mabp_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned IN_W     = 8 * CH_W;
  localparam int unsigned OUT_W    = 4 * CH_W;
  localparam int unsigned PROD_W   = 2 * CH_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CH_W-1:0] CH_MAX = 8'hff;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MUL_RED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUL_GREEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MUL_BLUE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MUL_ALPHA    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 3'd4;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
  } pixel_t;

  // After modulation
  typedef struct packed {
    chan_t  mod_red;
    chan_t  mod_green;
    chan_t  mod_blue;
    chan_t  eff_alpha;
    pixel_t dst;
    logic   src_clear;
    logic   blend;
  } s1_t;

  // After the mix multiplications
  typedef struct packed {
    prod_t        dst_red_p;
    prod_t        dst_green_p;
    prod_t        dst_blue_p;
    prod_t        src_red_p;
    prod_t        src_green_p;
    prod_t        src_blue_p;
    logic [CH_W:0] alpha_sum;
    s1_t          mod;
  } s2_t;

  typedef struct packed {
    pixel_t pix;
    logic   write_pixel;
  } s3_t;

endpackage

`default_nettype wire

/* hw/rtl/modulated_alpha_blend_pixel.sv */
// Top level of the modulated alpha blend pixel pipeline: config registers
// and three pipeline stages. Depends on mabp_pkg.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: src rgba, dst rgba
//  m_axis    out  m_axis_tvalid/tready       tdata: out rgba, tuser: write_pixel
//  cfg       in   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One pixel per clock sustained while m_axis accepts; an input transfer
// passes through three registered stages to m_axis (modulate, mix multiply,
// sum/select).
// Each stage has its own valid bit and loads when it is empty or the next
// stage loads, so bubbles collapse and a stall on m_axis backs up stage by
// stage. Reset (synchronous) clears valid bits and loads register defaults.
`default_nettype none

module modulated_alpha_blend_pixel (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // src_red, src_green, src_blue, src_opacity, dst_red, dst_green, dst_blue,
  // dst_alpha, 8 bits each from bit 0 up
  input  wire logic [mabp_pkg::IN_W-1:0]      s_axis_tdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // out_red, out_green, out_blue, out_alpha, 8 bits each from bit 0 up
  output logic [mabp_pkg::OUT_W-1:0]          m_axis_tdata,
  // write_pixel
  output logic                                m_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mabp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mabp_pkg::CH_W-1:0]      cfg_data
);

  mabp_pkg::chan_t mul_red;
  mabp_pkg::chan_t mul_green;
  mabp_pkg::chan_t mul_blue;
  mabp_pkg::chan_t mul_alpha;
  logic            blend_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_red      <= mabp_pkg::CH_MAX;
      mul_green    <= mabp_pkg::CH_MAX;
      mul_blue     <= mabp_pkg::CH_MAX;
      mul_alpha    <= mabp_pkg::CH_MAX;
      blend_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mabp_pkg::REG_MUL_RED:      mul_red      <= cfg_data;
        mabp_pkg::REG_MUL_GREEN:    mul_green    <= cfg_data;
        mabp_pkg::REG_MUL_BLUE:     mul_blue     <= cfg_data;
        mabp_pkg::REG_MUL_ALPHA:    mul_alpha    <= cfg_data;
        mabp_pkg::REG_BLEND_ENABLE: blend_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage handshake
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3 || m_axis_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Stage 1: modulate source channels and pick the effective alpha
  mabp_pkg::pixel_t src_in, dst_in;
  mabp_pkg::chan_t  alpha_sel;
  mabp_pkg::prod_t  pr, pg, pb, pa;
  mabp_pkg::s1_t    s1_next, s1;

  always_comb begin
    src_in.red   = s_axis_tdata[7:0];
    src_in.green = s_axis_tdata[15:8];
    src_in.blue  = s_axis_tdata[23:16];
    src_in.alpha = s_axis_tdata[31:24];
    dst_in.red   = s_axis_tdata[39:32];
    dst_in.green = s_axis_tdata[47:40];
    dst_in.blue  = s_axis_tdata[55:48];
    dst_in.alpha = s_axis_tdata[63:56];

    // opaque coverage when the destination is empty
    alpha_sel = (blend_enable && dst_in.alpha == '0) ? mabp_pkg::CH_MAX : src_in.alpha;

    pr = mabp_pkg::prod_t'(mul_red)   * mabp_pkg::prod_t'(src_in.red);
    pg = mabp_pkg::prod_t'(mul_green) * mabp_pkg::prod_t'(src_in.green);
    pb = mabp_pkg::prod_t'(mul_blue)  * mabp_pkg::prod_t'(src_in.blue);
    pa = mabp_pkg::prod_t'(mul_alpha) * mabp_pkg::prod_t'(alpha_sel);

    s1_next.mod_red   = pr[15:8];
    s1_next.mod_green = pg[15:8];
    s1_next.mod_blue  = pb[15:8];
    s1_next.eff_alpha = pa[15:8];
    s1_next.dst       = dst_in;
    s1_next.src_clear = (src_in.alpha == '0);
    s1_next.blend     = blend_enable;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) s1 <= s1_next;
  end

  // Stage 2: mix products and alpha sum
  mabp_pkg::chan_t inv_alpha;
  mabp_pkg::s2_t   s2_next, s2;

  always_comb begin
    inv_alpha = mabp_pkg::CH_MAX - s1.eff_alpha;
    s2_next.dst_red_p   = mabp_pkg::prod_t'(s1.dst.red)   * mabp_pkg::prod_t'(inv_alpha);
    s2_next.dst_green_p = mabp_pkg::prod_t'(s1.dst.green) * mabp_pkg::prod_t'(inv_alpha);
    s2_next.dst_blue_p  = mabp_pkg::prod_t'(s1.dst.blue)  * mabp_pkg::prod_t'(inv_alpha);
    s2_next.src_red_p   = mabp_pkg::prod_t'(s1.mod_red)   * mabp_pkg::prod_t'(s1.eff_alpha);
    s2_next.src_green_p = mabp_pkg::prod_t'(s1.mod_green) * mabp_pkg::prod_t'(s1.eff_alpha);
    s2_next.src_blue_p  = mabp_pkg::prod_t'(s1.mod_blue)  * mabp_pkg::prod_t'(s1.eff_alpha);
    s2_next.alpha_sum   = {1'b0, s1.dst.alpha} + {1'b0, s1.eff_alpha};
    s2_next.mod         = s1;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) s2 <= s2_next;
  end

  // Stage 3: sum, saturate and select by mode
  mabp_pkg::s3_t s3_next, s3;

  always_comb begin
    priority if (!s2.mod.blend) begin
      s3_next.pix.red     = s2.mod.mod_red;
      s3_next.pix.green   = s2.mod.mod_green;
      s3_next.pix.blue    = s2.mod.mod_blue;
      s3_next.pix.alpha   = s2.mod.eff_alpha;
      s3_next.write_pixel = 1'b1;
    end else if (s2.mod.src_clear) begin
      // transparent source: pass destination through, no write
      s3_next.pix         = s2.mod.dst;
      s3_next.write_pixel = 1'b0;
    end else begin
      // the channel sum may carry past 8 bits; keep the low byte
      s3_next.pix.red     = s2.dst_red_p[15:8]   + s2.src_red_p[15:8];
      s3_next.pix.green   = s2.dst_green_p[15:8] + s2.src_green_p[15:8];
      s3_next.pix.blue    = s2.dst_blue_p[15:8]  + s2.src_blue_p[15:8];
      s3_next.pix.alpha   = s2.alpha_sum[8] ? mabp_pkg::CH_MAX : s2.alpha_sum[7:0];
      s3_next.write_pixel = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) s3 <= s3_next;
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {s3.pix.alpha, s3.pix.blue, s3.pix.green, s3.pix.red};
  assign m_axis_tuser  = s3.write_pixel;

endmodule

`default_nettype wire

/* tb/tb_modulated_alpha_blend_pixel.sv */
// Self-checking testbench for modulated_alpha_blend_pixel: predicts every pixel
// in copy and blend mode over many register settings, under random idling on
// both streams. Depends on mabp_pkg and the RTL of the block.
`default_nettype none

module tb_modulated_alpha_blend_pixel;
  import mabp_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 600000;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned PIXELS_PER_PHASE = 205;

  typedef struct {
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;
    logic  write_pixel;
  } blend_result_t;

  class pixel_blend_checker;
    chan_t         mul_red;
    chan_t         mul_green;
    chan_t         mul_blue;
    chan_t         mul_alpha;
    logic          blend_on;
    blend_result_t pending_pixels[$];
    int unsigned   mismatches;
    int unsigned   checked;

    function new();
      mul_red    = CH_MAX;
      mul_green  = CH_MAX;
      mul_blue   = CH_MAX;
      mul_alpha  = CH_MAX;
      blend_on   = 1'b0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, chan_t val);
      case (idx)
        REG_MUL_RED:      mul_red = val;
        REG_MUL_GREEN:    mul_green = val;
        REG_MUL_BLUE:     mul_blue = val;
        REG_MUL_ALPHA:    mul_alpha = val;
        REG_BLEND_ENABLE: blend_on = val[0];
        default: ;
      endcase
    endfunction

    function chan_t scale(chan_t m, chan_t s);
      prod_t p;
      p = m * s;
      return p[PROD_W-1:CH_W];
    endfunction

    function chan_t mix(chan_t d, chan_t c, chan_t a);
      prod_t         pd;
      prod_t         pc;
      logic [CH_W:0] sum;
      pd  = d * (CH_MAX - a);
      pc  = c * a;
      sum = pd[PROD_W-1:CH_W] + pc[PROD_W-1:CH_W];
      return sum[CH_W-1:0];
    endfunction

    function blend_result_t blend_pixel(logic [IN_W-1:0] d);
      chan_t         sa;
      chan_t         dr;
      chan_t         dg;
      chan_t         db;
      chan_t         da;
      chan_t         ea;
      logic [CH_W:0] asum;
      blend_result_t r;
      sa = d[3*CH_W +: CH_W];
      dr = d[4*CH_W +: CH_W];
      dg = d[5*CH_W +: CH_W];
      db = d[6*CH_W +: CH_W];
      da = d[7*CH_W +: CH_W];
      r.red         = scale(mul_red, d[0 +: CH_W]);
      r.green       = scale(mul_green, d[CH_W +: CH_W]);
      r.blue        = scale(mul_blue, d[2*CH_W +: CH_W]);
      r.alpha       = scale(mul_alpha, sa);
      r.write_pixel = 1'b1;
      if (blend_on && sa == '0) begin
        // transparent source: pass the destination through, no write
        r.red         = dr;
        r.green       = dg;
        r.blue        = db;
        r.alpha       = da;
        r.write_pixel = 1'b0;
      end else if (blend_on) begin
        // an empty destination takes the source as fully opaque
        ea      = scale(mul_alpha, (da == '0) ? CH_MAX : sa);
        r.red   = mix(dr, r.red, ea);
        r.green = mix(dg, r.green, ea);
        r.blue  = mix(db, r.blue, ea);
        asum    = da + ea;
        r.alpha = (asum > CH_MAX) ? CH_MAX : asum[CH_W-1:0];
      end
      return r;
    endfunction

    function void note_pixel(logic [IN_W-1:0] d);
      pending_pixels.push_back(blend_pixel(d));
    endfunction

    function void compare(string field, chan_t want, chan_t got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t: %s expected %02h got %02h", $time, field, want, got);
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic wr);
      blend_result_t e;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t: result with none pending, expected nothing got %08h/%0b",
                   $time, data, wr);
        return;
      end
      e = pending_pixels.pop_front();
      checked++;
      compare("out_red", e.red, data[0 +: CH_W]);
      compare("out_green", e.green, data[CH_W +: CH_W]);
      compare("out_blue", e.blue, data[2*CH_W +: CH_W]);
      compare("out_alpha", e.alpha, data[3*CH_W +: CH_W]);
      compare("write_pixel", chan_t'(e.write_pixel), chan_t'(wr));
    endfunction
  endclass

  logic                 clk;
  logic                 rst           = 1'b1;
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  chan_t                cfg_data      = '0;

  bit                   tx_gaps       = 1'b0;
  bit                   rx_stalls     = 1'b0;
  int unsigned          stall_left    = 0;
  int unsigned          cycles        = 0;
  int unsigned          settings_used = 0;
  pixel_blend_checker   board;

  modulated_alpha_blend_pixel uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [IN_W-1:0] pix(chan_t sr, chan_t sg, chan_t sb, chan_t sa,
                                          chan_t dr, chan_t dg, chan_t db, chan_t da);
    return {da, db, dg, dr, sa, sb, sg, sr};
  endfunction

  function automatic logic [IN_W-1:0] random_pixels();
    logic [IN_W-1:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: d[3*CH_W +: CH_W] = '0;
      1: d[7*CH_W +: CH_W] = '0;
      2: d[3*CH_W +: CH_W] = CH_MAX;
      3: begin
        d[3*CH_W +: CH_W] = CH_MAX;
        d[7*CH_W +: CH_W] = CH_MAX;
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic chan_t pick_factor();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CH_MAX;
      default: return chan_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_stalls && $urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  // Keep tvalid high across back-to-back transfers; lower it only for a gap.
  task automatic send_pixels(input logic [IN_W-1:0] d);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_pixel(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input chan_t val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic load_settings(input chan_t r, input chan_t g, input chan_t b, input chan_t a,
                               input chan_t blend);
    logic [CFG_IDX_W-1:0] junk_idx;
    junk_idx = CFG_IDX_W'($urandom_range(REG_BLEND_ENABLE + 1, (1 << CFG_IDX_W) - 1));
    drain();
    write_reg(REG_MUL_RED, r);
    write_reg(REG_MUL_GREEN, g);
    write_reg(REG_MUL_BLUE, b);
    write_reg(REG_MUL_ALPHA, a);
    write_reg(REG_BLEND_ENABLE, blend);
    // an index past the register list must change nothing
    write_reg(junk_idx, chan_t'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // copy mode at the reset factors
    send_pixels(pix(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixels(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixels(pix(8'haa, 8'haa, 8'haa, 8'haa, 8'h55, 8'h55, 8'h55, 8'h55));
    send_pixels(pix(8'h55, 8'h55, 8'h55, 8'h00, 8'haa, 8'haa, 8'haa, 8'haa));

    load_settings(8'h80, 8'hc0, 8'h40, 8'hff, 8'h01);
    send_pixels(pix(8'h12, 8'h34, 8'h56, 8'h00, 8'h9a, 8'hbc, 8'hde, 8'h78));
    send_pixels(pix(8'hf0, 8'h0f, 8'h88, 8'h10, 8'h20, 8'h40, 8'h60, 8'h00));
    send_pixels(pix(8'hff, 8'h80, 8'h01, 8'hff, 8'h7f, 8'h3c, 8'hc3, 8'hff));
    send_pixels(pix(8'h64, 8'hc8, 8'h32, 8'hc8, 8'h10, 8'h20, 8'h30, 8'hc8));
    send_pixels(pix(8'hff, 8'hff, 8'hff, 8'h01, 8'hff, 8'hff, 8'hff, 8'h01));
    send_pixels(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixels(pix(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_pixels(pix(8'h11, 8'h22, 8'h33, 8'h00, 8'h44, 8'h55, 8'h66, 8'h00));

    load_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
    send_pixels(pix(8'hff, 8'hff, 8'hff, 8'hff, 8'hc0, 8'h81, 8'h7e, 8'h64));
    send_pixels(pix(8'hff, 8'hff, 8'hff, 8'h80, 8'hff, 8'hff, 8'hff, 8'h00));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_settings(CH_MAX, CH_MAX, CH_MAX, CH_MAX, chan_t'($urandom) | 8'h01);
        1: load_settings('0, '0, '0, '0, 8'h01);
        // upper bits of the enable value set, enable bit clear
        2: load_settings(CH_MAX, '0, CH_MAX, '0, 8'hfe);
        default: load_settings(pick_factor(), pick_factor(), pick_factor(), pick_factor(),
                               chan_t'($urandom));
      endcase
      tx_gaps   = p[0];
      rx_stalls = p[1];
      repeat (PIXELS_PER_PHASE) send_pixels(random_pixels());
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d pixels under %0d register settings in copy and blend mode,",
             board.checked, settings_used);
    $display("with sender gaps and receiver stalls switched on and off.");
    if (board.mismatches == 0 && board.pending_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
